/* rtl/ppc_pkg.sv */
// Types and constants shared by the point/polygon classifier modules.
package ppc_pkg;

  localparam int COORD_W = 24;
  localparam int OP_W    = 27;
  localparam int ACC_W   = 56;
  localparam int LEN_W   = 50;
  localparam int T_W     = 16;
  localparam int D2_W    = 52;
  localparam int DIST_W  = 26;
  localparam int WIND_W  = 12;

  localparam logic signed [WIND_W-1:0] WIND_MAX = 12'sh7ff;
  localparam logic signed [WIND_W-1:0] WIND_MIN = 12'sh800;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic                      last_edge;
  } req_t;

  typedef struct packed {
    logic              inside_res;
    logic [DIST_W-1:0] distance;
  } rsp_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic sub;
  } mac_ctl_t;

endpackage

/* rtl/ppc_mac.sv */
// Shared signed multiply-accumulate unit.
module ppc_mac (
  input  logic                                clk,
  input  ppc_pkg::mac_ctl_t                   ctl,
  input  logic signed [ppc_pkg::OP_W-1:0]     a,
  input  logic signed [ppc_pkg::OP_W-1:0]     b,
  output logic signed [ppc_pkg::ACC_W-1:0]    acc
);

  logic signed [2*ppc_pkg::OP_W-1:0]  prod;
  logic signed [ppc_pkg::ACC_W-1:0]   prod_ext;
  logic signed [ppc_pkg::ACC_W-1:0]   base;

  assign prod     = a * b;
  assign prod_ext = ppc_pkg::ACC_W'(prod);
  assign base     = ctl.clr ? '0 : acc;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= ctl.sub ? base - prod_ext : base + prod_ext;
    end
  end

endmodule

/* rtl/ppc_div.sv */
// Restoring divider, one quotient bit per cycle, for the projection parameter.
module ppc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppc_pkg::LEN_W-1:0]     dividend,
  input  logic [ppc_pkg::LEN_W-1:0]     divisor,
  output logic                          busy,
  output logic [ppc_pkg::T_W-1:0]       quot
);

  logic [ppc_pkg::LEN_W:0]   r;
  logic [ppc_pkg::LEN_W:0]   r2;
  logic [ppc_pkg::LEN_W-1:0] dvs;
  logic [4:0]                cnt;

  assign r2 = {r[ppc_pkg::LEN_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(ppc_pkg::T_W);
      r    <= {1'b0, dividend};
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      if (r2 >= {1'b0, dvs}) begin
        r    <= r2 - {1'b0, dvs};
        quot <= {quot[ppc_pkg::T_W-2:0], 1'b1};
      end else begin
        r    <= r2;
        quot <= {quot[ppc_pkg::T_W-2:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/ppc_sqrt.sv */
// Digit-by-digit integer square root, one result bit per cycle.
module ppc_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppc_pkg::D2_W-1:0]      value,
  output logic                          busy,
  output logic [ppc_pkg::DIST_W-1:0]    root
);

  logic [ppc_pkg::D2_W-1:0]     src;
  logic [ppc_pkg::DIST_W+3:0]   rem;
  logic [ppc_pkg::DIST_W+3:0]   rem_sh;
  logic [ppc_pkg::DIST_W+3:0]   trial;
  logic [4:0]                   cnt;

  assign rem_sh = {rem[ppc_pkg::DIST_W+1:0], src[ppc_pkg::D2_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'(ppc_pkg::DIST_W);
      src  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src <= {src[ppc_pkg::D2_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[ppc_pkg::DIST_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ppc_pkg::DIST_W-2:0], 1'b0};
      end
      cnt <= cnt - 5'd1;
      if (cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* rtl/point_polygon_classifier.sv */
// Point-in-polygon classifier (non-zero winding) with nearest-edge distance.
//
//  channel  signals                      payload
//  request  req_valid / req_ready        req_data  (ppc_pkg::req_t, one edge)
//  result   rsp_valid / rsp_ready        rsp_data  (ppc_pkg::rsp_t, on last edge)
//
// One edge keeps the sequencer busy through the cross, length and dot steps on
// the shared multiplier, then through the 16-step divider and the projection
// steps when the point projects inside the segment, before it returns to idle.
// The last edge adds the square root and the result load, plus any output stall.
// req_ready is high only while the sequencer is idle; a pending result
// does not block the next request. Reset is synchronous and clears state.
module point_polygon_classifier (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  ppc_pkg::req_t   req_data,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output ppc_pkg::rsp_t   rsp_data
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CR1  = 5'd1;
  localparam logic [4:0] S_CR2  = 5'd2;
  localparam logic [4:0] S_LN1  = 5'd3;
  localparam logic [4:0] S_LN2  = 5'd4;
  localparam logic [4:0] S_DT1  = 5'd5;
  localparam logic [4:0] S_DT2  = 5'd6;
  localparam logic [4:0] S_BR   = 5'd7;
  localparam logic [4:0] S_DIV  = 5'd8;
  localparam logic [4:0] S_PX   = 5'd9;
  localparam logic [4:0] S_PY   = 5'd10;
  localparam logic [4:0] S_PU   = 5'd11;
  localparam logic [4:0] S_SQ1  = 5'd12;
  localparam logic [4:0] S_SQ2  = 5'd13;
  localparam logic [4:0] S_UPD  = 5'd14;
  localparam logic [4:0] S_RT   = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  localparam int OW = ppc_pkg::OP_W;

  logic [4:0] state;
  logic [4:0] state_next;

  logic signed [OW-1:0] ex, ey, qx, qy, fx, fy, ux, uy;
  logic ay_le, by_gt, last_q, cross_pos, cross_neg;
  logic [ppc_pkg::LEN_W-1:0] len2;
  logic signed [ppc_pkg::ACC_W-1:0] dot;
  logic signed [ppc_pkg::WIND_W-1:0] wind;
  logic [ppc_pkg::D2_W-1:0] lsd;

  ppc_pkg::mac_ctl_t mctl;
  logic signed [OW-1:0] ma, mb;
  logic signed [ppc_pkg::ACC_W-1:0] acc;

  logic div_start, div_busy, rt_start, rt_busy;
  logic [ppc_pkg::T_W-1:0] tq;
  logic [ppc_pkg::DIST_W-1:0] root;

  logic [ppc_pkg::D2_W-1:0] d2, d2_min;
  logic [ppc_pkg::ACC_W-1:0] rx_sum;
  logic signed [OW-1:0] rx;
  logic signed [OW-1:0] abs_ex, abs_ey, t_op;
  logic near_start, far_end;
  logic req_fire, out_load;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  assign abs_ex = ex[OW-1] ? -ex : ex;
  assign abs_ey = ey[OW-1] ? -ey : ey;
  assign t_op   = OW'(tq);
  assign rx_sum = ppc_pkg::ACC_W'(acc) + ppc_pkg::ACC_W'(1 << (ppc_pkg::T_W - 1));
  assign rx     = OW'(rx_sum[ppc_pkg::ACC_W-1:ppc_pkg::T_W]);

  assign d2     = acc[ppc_pkg::D2_W-1:0];
  assign d2_min = (d2 < lsd) ? d2 : lsd;

  assign near_start = (len2 == '0) || (acc <= 0);
  assign far_end    = acc >= $signed({{(ppc_pkg::ACC_W-ppc_pkg::LEN_W){1'b0}}, len2});

  assign div_start = (state == S_BR) && !near_start && !far_end;
  assign rt_start  = (state == S_UPD) && last_q;
  assign out_load  = (state == S_OUT) && (!rsp_valid || rsp_ready);

  always_comb begin
    mctl = '0;
    ma   = '0;
    mb   = '0;
    case (state)
      S_CR1: begin mctl = '{1'b1, 1'b1, 1'b0}; ma = ex;     mb = qy;   end
      S_CR2: begin mctl = '{1'b1, 1'b0, 1'b1}; ma = qx;     mb = ey;   end
      S_LN1: begin mctl = '{1'b1, 1'b1, 1'b0}; ma = ex;     mb = ex;   end
      S_LN2: begin mctl = '{1'b1, 1'b0, 1'b0}; ma = ey;     mb = ey;   end
      S_DT1: begin mctl = '{1'b1, 1'b1, 1'b0}; ma = qx;     mb = ex;   end
      S_DT2: begin mctl = '{1'b1, 1'b0, 1'b0}; ma = qy;     mb = ey;   end
      S_PX:  begin mctl = '{1'b1, 1'b1, 1'b0}; ma = abs_ex; mb = t_op; end
      S_PY:  begin mctl = '{1'b1, 1'b1, 1'b0}; ma = abs_ey; mb = t_op; end
      S_SQ1: begin mctl = '{1'b1, 1'b1, 1'b0}; ma = ux;     mb = ux;   end
      S_SQ2: begin mctl = '{1'b1, 1'b0, 1'b0}; ma = uy;     mb = uy;   end
      default: begin end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (req_fire) state_next = S_CR1;
      S_CR1:  state_next = S_CR2;
      S_CR2:  state_next = S_LN1;
      S_LN1:  state_next = S_LN2;
      S_LN2:  state_next = S_DT1;
      S_DT1:  state_next = S_DT2;
      S_DT2:  state_next = S_BR;
      S_BR:   state_next = (near_start || far_end) ? S_SQ1 : S_DIV;
      S_DIV:  if (!div_busy) state_next = S_PX;
      S_PX:   state_next = S_PY;
      S_PY:   state_next = S_PU;
      S_PU:   state_next = S_SQ1;
      S_SQ1:  state_next = S_SQ2;
      S_SQ2:  state_next = S_UPD;
      S_UPD:  state_next = last_q ? S_RT : S_IDLE;
      S_RT:   if (!rt_busy) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wind      <= '0;
      lsd       <= '1;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_UPD) begin
        lsd <= d2_min;
        if (ay_le && by_gt && cross_pos && wind != ppc_pkg::WIND_MAX) begin
          wind <= wind + 12'sd1;
        end else if (!ay_le && !by_gt && cross_neg && wind != ppc_pkg::WIND_MIN) begin
          wind <= wind - 12'sd1;
        end
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
        wind      <= '0;
        lsd       <= '1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      ex     <= OW'(req_data.end_x) - OW'(req_data.start_x);
      ey     <= OW'(req_data.end_y) - OW'(req_data.start_y);
      qx     <= OW'(req_data.point_x) - OW'(req_data.start_x);
      qy     <= OW'(req_data.point_y) - OW'(req_data.start_y);
      fx     <= OW'(req_data.point_x) - OW'(req_data.end_x);
      fy     <= OW'(req_data.point_y) - OW'(req_data.end_y);
      ay_le  <= req_data.start_y <= req_data.point_y;
      by_gt  <= req_data.end_y > req_data.point_y;
      last_q <= req_data.last_edge;
    end
    case (state)
      S_LN1: begin
        cross_pos <= acc > 0;
        cross_neg <= acc < 0;
      end
      S_DT1: len2 <= acc[ppc_pkg::LEN_W-1:0];
      S_BR: begin
        dot <= acc;
        ux  <= far_end ? fx : qx;
        uy  <= far_end ? fy : qy;
      end
      S_PY: ux <= ex[OW-1] ? qx + rx : qx - rx;
      S_PU: uy <= ey[OW-1] ? qy + rx : qy - rx;
      default: begin end
    endcase
    if (out_load) begin
      rsp_data.inside_res <= (wind != '0);
      rsp_data.distance   <= root;
    end
  end

  ppc_mac u_mac (
    .clk (clk),
    .ctl (mctl),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  ppc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc[ppc_pkg::LEN_W-1:0]),
    .divisor  (len2),
    .busy     (div_busy),
    .quot     (tq)
  );

  ppc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (rt_start),
    .value (d2_min),
    .busy  (rt_busy),
    .root  (root)
  );

  a_one_edge: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("request accepted while an edge is in progress");

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PX) |-> (dot > 0) &&
      (dot < $signed({{(ppc_pkg::ACC_W-ppc_pkg::LEN_W){1'b0}}, len2})))
    else $error("projection taken outside the open segment");

  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside the output step");

  a_root_last: assert property (@(posedge clk) disable iff (rst)
    rt_start |-> last_q && !rt_busy)
    else $error("square root started on a non-final edge");

endmodule
